// File: hdl/graph_edge_table_engine_unit_assert.svh
// assertion macros for the edge table engine
`ifndef GRAPH_EDGE_TABLE_ENGINE_UNIT_ASSERT_SVH
`define GRAPH_EDGE_TABLE_ENGINE_UNIT_ASSERT_SVH
// implication checked every clock outside reset
`define GETE_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// next-cycle implication
`define GETE_ASSERT_NXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

// File: hdl/gete_pkg.sv
// shared types and codes for the edge table engine
package gete_pkg;
  typedef enum logic [2:0] {
    CMD_ADD = 3'd0, CMD_LOOKUP = 3'd1, CMD_LIST = 3'd2, CMD_COLLECT = 3'd3, CMD_CLEAR = 3'd4
  } cmd_t;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;
  localparam int MAX_OUT = 64;
  localparam int IN_W = 160;
  localparam int OUT_W = 96;

  typedef struct packed {
    logic load;        // latch input word
    logic wr_edge;     // append edge
    logic clr_total;   // clear table
    logic scan_clr;    // reset scan index, slot count
    logic scan_step;   // advance scan index
    logic scan_rd;     // read entry at scan index
    logic slot_wr;     // store collected entry
    logic sort_clr;    // start sort pass
    logic sort_step;   // one compare-swap step
    logic emit_clr;    // reset emit index
    logic emit_step;   // advance emit index
  } gete_cmd_t;

  typedef struct packed {
    logic scan_done;   // index reached total
    logic hit_list;    // read entry matches source
    logic hit_lookup;  // matches source, port, label
    logic hit_arg;     // matches source and argument label
    logic slots_full;
    logic full;        // table at capacity
    logic sort_done;   // a full pass made no swap and ended
    logic pass_end;
    logic emit_done;
    logic limit_zero;
  } gete_stat_t;
endpackage

// File: hdl/graph_edge_table_engine_unit.sv
// top level of the graph edge table engine
// channel | dir | tdata fields (low bit up)                      | tuser/tlast
// s_axis  | in  | command, source_id, target_id, port_num,       | -
//         |     | label_code, limit (153 bits, padded to 160)    |
// m_axis  | out | result_target, result_port, result_label,      | tlast = last
//         |     | status, edge_total (89 bits, padded to 96)     |
// cfg     | in  | argument_label (8 bits)                        | -
// add and clear go through dispatch and one final word; lookup and list read and check
// each stored edge in turn; collect adds a bubble sort of the slots, then emits targets.
// one command at a time; output stalls hold the scan in place.
// rst is synchronous; the table is empty and argument_label is 0 after reset.
module graph_edge_table_engine_unit #(
  parameter int EDGE_DEPTH = 64,
  parameter int ARG_SLOTS = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // command, source_id, target_id, port_num, label_code, limit
  input  logic [gete_pkg::IN_W-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // result_target, result_port, result_label, status, edge_total
  output logic [gete_pkg::OUT_W-1:0] m_axis_tdata,
  output logic m_axis_tlast,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [7:0] cfg_data
);
  import gete_pkg::*;
  localparam int CW = $clog2(EDGE_DEPTH+1);
  gete_cmd_t cmd;
  gete_stat_t stat;
  logic [7:0] argument_label;
  logic [2:0] cur_cmd;
  logic [63:0] rd_target, slot_target, o_target;
  logic [7:0] rd_port, rd_label, slot_port, o_port, o_label;
  logic [CW-1:0] total;
  logic [1:0] o_status;
  logic [6:0] o_total;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) argument_label <= '0;
    else if (cfg_valid && cfg_ready) argument_label <= cfg_data;
  end

  gete_datapath #(.EDGE_DEPTH(EDGE_DEPTH), .ARG_SLOTS(ARG_SLOTS)) u_dp (
    .clk, .rst, .argument_label,
    .command(s_axis_tdata[2:0]), .source_id(s_axis_tdata[66:3]),
    .target_id(s_axis_tdata[130:67]), .port_num(s_axis_tdata[138:131]),
    .label_code(s_axis_tdata[146:139]), .limit(s_axis_tdata[152:147]),
    .cmd, .stat, .cur_cmd, .rd_target, .rd_port, .rd_label,
    .slot_target, .slot_port, .total
  );

  gete_ctrl #(.CW(CW)) u_ctrl (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .cur_cmd, .stat, .cmd,
    .rd_target, .rd_port, .rd_label, .slot_target, .slot_port, .total,
    .o_target, .o_port, .o_label, .o_status, .o_total, .o_last(m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, o_total, o_status, o_label, o_port, o_target};
endmodule

// File: hdl/gete_datapath.sv
// edge memory, scan, argument slots and sorter
module gete_datapath #(
  parameter int EDGE_DEPTH = 64,
  parameter int ARG_SLOTS = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic [7:0] argument_label,
  input  logic [2:0] command,
  input  logic [63:0] source_id,
  input  logic [63:0] target_id,
  input  logic [7:0] port_num,
  input  logic [7:0] label_code,
  input  logic [5:0] limit,
  input  gete_pkg::gete_cmd_t cmd,
  output gete_pkg::gete_stat_t stat,
  output logic [2:0] cur_cmd,
  output logic [63:0] rd_target,
  output logic [7:0] rd_port,
  output logic [7:0] rd_label,
  output logic [63:0] slot_target,
  output logic [7:0] slot_port,
  output logic [$clog2(EDGE_DEPTH+1)-1:0] total
);
  import gete_pkg::*;
  localparam int AW = $clog2(EDGE_DEPTH);
  localparam int CW = $clog2(EDGE_DEPTH+1);
  localparam int SW = (ARG_SLOTS > 1) ? $clog2(ARG_SLOTS) : 1;
  localparam int SCW = $clog2(ARG_SLOTS+1);

  logic [63:0] mem_src [EDGE_DEPTH];
  logic [63:0] mem_tgt [EDGE_DEPTH];
  logic [7:0]  mem_port [EDGE_DEPTH];
  logic [7:0]  mem_lab [EDGE_DEPTH];
  logic [63:0] q_src, q_tgt;
  logic [7:0]  q_port, q_lab;
  logic [5:0]  q_limit;
  logic [CW-1:0] idx;
  logic [63:0] rd_src;
  logic [7:0] slot_p [ARG_SLOTS];
  logic [63:0] slot_t [ARG_SLOTS];
  logic [SCW-1:0] slots;
  logic [SCW-1:0] spos;
  logic swapped;
  logic [SCW-1:0] eidx;
  logic [6:0] emit_n;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_cmd <= command;
      q_src <= source_id;
      q_tgt <= target_id;
      q_port <= port_num;
      q_lab <= label_code;
      q_limit <= limit;
    end
    if (cmd.wr_edge) begin
      mem_src[total[AW-1:0]] <= q_src;
      mem_tgt[total[AW-1:0]] <= q_tgt;
      mem_port[total[AW-1:0]] <= q_port;
      mem_lab[total[AW-1:0]] <= q_lab;
    end
    if (cmd.scan_rd) begin
      rd_src <= mem_src[idx[AW-1:0]];
      rd_target <= mem_tgt[idx[AW-1:0]];
      rd_port <= mem_port[idx[AW-1:0]];
      rd_label <= mem_lab[idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (cmd.clr_total) begin
      total <= '0;
    end else if (cmd.wr_edge) begin
      total <= total + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      slots <= '0;
    end else if (cmd.scan_clr) begin
      idx <= '0;
      slots <= '0;
    end else begin
      if (cmd.scan_step) idx <= idx + CW'(1);
      if (cmd.slot_wr) begin
        slot_p[slots[SW-1:0]] <= rd_port;
        slot_t[slots[SW-1:0]] <= rd_target;
        slots <= slots + SCW'(1);
      end
    end
    if (cmd.sort_clr) begin
      spos <= SCW'(1);
      swapped <= 1'b0;
    end else if (cmd.sort_step) begin
      if (stat.pass_end) begin
        spos <= SCW'(1);
        swapped <= 1'b0;
      end else begin
        spos <= spos + SCW'(1);
        if (slot_p[spos[SW-1:0] - SW'(1)] > slot_p[spos[SW-1:0]]) begin
          slot_p[spos[SW-1:0] - SW'(1)] <= slot_p[spos[SW-1:0]];
          slot_p[spos[SW-1:0]] <= slot_p[spos[SW-1:0] - SW'(1)];
          slot_t[spos[SW-1:0] - SW'(1)] <= slot_t[spos[SW-1:0]];
          slot_t[spos[SW-1:0]] <= slot_t[spos[SW-1:0] - SW'(1)];
          swapped <= 1'b1;
        end
      end
    end
    if (cmd.emit_clr) eidx <= '0;
    else if (cmd.emit_step) eidx <= eidx + SCW'(1);
  end

  always_comb begin
    emit_n = (7'(slots) < 7'(q_limit)) ? 7'(slots) : 7'(q_limit);
    slot_target = slot_t[eidx[SW-1:0]];
    slot_port = slot_p[eidx[SW-1:0]];
    stat.scan_done = (idx >= total);
    stat.hit_list = (rd_src == q_src);
    stat.hit_lookup = (rd_src == q_src) && (rd_port == q_port) && (rd_label == q_lab);
    stat.hit_arg = (rd_src == q_src) && (rd_label == argument_label);
    stat.slots_full = (slots == SCW'(ARG_SLOTS));
    stat.full = (total == CW'(EDGE_DEPTH));
    stat.pass_end = (spos >= slots);
    stat.sort_done = stat.pass_end && !swapped;
    stat.emit_done = (7'(eidx) + 7'd1 >= emit_n);
    stat.limit_zero = (emit_n == 7'd0);
  end

  `include "graph_edge_table_engine_unit_assert.svh"
  `GETE_ASSERT_IMP(a_total_bound, clk, rst, 1'b1, total <= CW'(EDGE_DEPTH), "total too big")
  `GETE_ASSERT_IMP(a_slots_bound, clk, rst, 1'b1, slots <= SCW'(ARG_SLOTS), "slots overflow")
  `GETE_ASSERT_IMP(a_no_write_full, clk, rst, cmd.wr_edge, !stat.full, "write when full")
endmodule

// File: hdl/gete_ctrl.sv
// command sequencer and output register
module gete_ctrl #(
  parameter int CW = 7
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  logic [2:0] cur_cmd,
  input  gete_pkg::gete_stat_t stat,
  output gete_pkg::gete_cmd_t cmd,
  input  logic [63:0] rd_target,
  input  logic [7:0] rd_port,
  input  logic [7:0] rd_label,
  input  logic [63:0] slot_target,
  input  logic [7:0] slot_port,
  input  logic [CW-1:0] total,
  output logic [63:0] o_target,
  output logic [7:0] o_port,
  output logic [7:0] o_label,
  output logic [1:0] o_status,
  output logic [6:0] o_total,
  output logic o_last
);
  import gete_pkg::*;
  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_RD, S_CHECK, S_SORT, S_EMIT, S_FINAL, S_WAIT
  } state_t;
  state_t state;
  logic [6:0] nout;
  logic hold;
  logic [63:0] pend_t;
  logic [7:0] pend_p, pend_l;
  logic pend;
  logic word_load;
  logic o_total_full_q;

  assign in_ready = (state == S_IDLE);
  assign hold = out_valid && !out_ready;
  // output register takes a new word this cycle
  assign word_load = !hold && ((state == S_EMIT) || (state == S_FINAL) ||
    (state == S_CHECK && cur_cmd == CMD_LIST && stat.hit_list &&
     nout < 7'(MAX_OUT) && pend));

  always_comb begin
    cmd = '0;
    cmd.load = (state == S_IDLE) && in_valid;
    cmd.scan_clr = cmd.load;
    case (state)
      S_DISPATCH: begin
        if (cur_cmd == CMD_ADD && !stat.full) cmd.wr_edge = 1'b1;
        if (cur_cmd == CMD_CLEAR) cmd.clr_total = 1'b1;
        cmd.sort_clr = 1'b1;
      end
      S_RD: cmd.scan_rd = !stat.scan_done && !hold;
      S_CHECK: begin
        if (!hold && cur_cmd == CMD_COLLECT && stat.hit_arg && !stat.slots_full)
          cmd.slot_wr = 1'b1;
        cmd.scan_step = !hold;
      end
      S_SORT: cmd.sort_step = 1'b1;
      S_EMIT: cmd.emit_step = !hold;
      default: ;
    endcase
    if (state == S_SORT && stat.sort_done) cmd.emit_clr = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      nout <= '0;
      pend <= 1'b0;
    end else begin
      if (out_valid && out_ready && !word_load) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid) begin
          state <= S_DISPATCH;
          nout <= '0;
          pend <= 1'b0;
        end
        S_DISPATCH: begin
          if (cur_cmd == CMD_LIST || cur_cmd == CMD_COLLECT || cur_cmd == CMD_LOOKUP)
            state <= S_RD;
          else state <= S_FINAL;
        end
        S_RD: if (!hold) begin
          if (stat.scan_done || (cur_cmd == CMD_COLLECT && stat.slots_full)) begin
            if (cur_cmd == CMD_COLLECT) state <= S_SORT;
            else state <= S_FINAL;
          end else state <= S_CHECK;
        end
        S_CHECK: if (!hold) begin
          if (cur_cmd == CMD_LOOKUP && stat.hit_lookup) begin
            pend <= 1'b1;
            pend_t <= rd_target;
            state <= S_FINAL;
          end else begin
            state <= S_RD;
            if (cur_cmd == CMD_LIST && stat.hit_list && nout < 7'(MAX_OUT)) begin
              if (pend) begin
                out_valid <= 1'b1;
                o_target <= pend_t;
                o_port <= pend_p;
                o_label <= pend_l;
                o_status <= ST_OK;
                o_total <= 7'(total);
                o_last <= 1'b0;
              end
              pend <= 1'b1;
              pend_t <= rd_target;
              pend_p <= rd_port;
              pend_l <= rd_label;
              nout <= nout + 7'd1;
            end
          end
        end
        S_SORT: if (stat.sort_done) state <= stat.limit_zero ? S_FINAL : S_EMIT;
        S_EMIT: if (!hold) begin
          out_valid <= 1'b1;
          o_target <= slot_target;
          o_port <= slot_port;
          o_label <= '0;
          o_status <= ST_OK;
          o_total <= 7'(total);
          o_last <= stat.emit_done;
          if (stat.emit_done) state <= S_WAIT;
        end
        S_FINAL: if (!hold) begin
          out_valid <= 1'b1;
          o_total <= 7'(total);
          o_last <= 1'b1;
          o_target <= pend ? pend_t : '0;
          o_port <= (pend && cur_cmd == CMD_LIST) ? pend_p : '0;
          o_label <= (pend && cur_cmd == CMD_LIST) ? pend_l : '0;
          if (pend) begin
            o_status <= ST_OK;
          end else if (cur_cmd == CMD_ADD) begin
            o_status <= stat.full && o_total_full_q ? ST_FULL : ST_OK;
          end else if (cur_cmd == CMD_CLEAR) begin
            o_status <= ST_OK;
          end else begin
            o_status <= ST_NONE;
          end
          state <= S_WAIT;
        end
        S_WAIT: if (!out_valid || out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) o_total_full_q <= 1'b0;
    else if (state == S_DISPATCH) o_total_full_q <= stat.full;
  end

  `include "graph_edge_table_engine_unit_assert.svh"
  `GETE_ASSERT_IMP(a_idle_ready, clk, rst, in_ready, !out_valid || state == S_IDLE, "ready bad")
  `GETE_ASSERT_NXT(a_load_leaves_idle, clk, rst, cmd.load, state == S_DISPATCH, "no dispatch")
  `GETE_ASSERT_IMP(a_nout_bound, clk, rst, 1'b1, nout <= 7'(MAX_OUT), "list overflow")
endmodule
